### src/schc_pkg.sv
// ----------------------------------------------------------------------------
// schc_pkg: shared definitions for the segment versus circle hit test
// Holds the default coordinate width, the pipeline depth and the control
// bundle that runs between the stage controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package schc_pkg;

  // Default width of one coordinate field.
  localparam int unsigned COORD_WIDTH_DEF = 16;

  // Number of register stages in the datapath, output register included.
  localparam int unsigned NUM_STAGES = 7;

  // Per-stage load enables and valid bits.
  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
    logic [NUM_STAGES-1:0] vld;
  } pipe_ctrl_t;

endpackage : schc_pkg

`default_nettype wire

### src/segment_circle_hit_test.sv
// ----------------------------------------------------------------------------
// segment_circle_hit_test: exact segment versus circle contact test
// Throughput: one transaction per cycle; the seven-stage multiply and
// add pipeline accepts a new pair in every cycle while results are taken.
// Reset: rst_ni clears all valid bits at once; the block is ready right
// after reset; the datapath registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_circle_hit_test
  import schc_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic signed [COORD_WIDTH-1:0] start_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] start_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] stop_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] stop_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] center_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] center_y_i,
  input  wire logic        [COORD_WIDTH-1:0] radius_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic                          hit_o
);

  // With v = center - start, d = stop - start and w = center - stop the
  // closest point of the segment decides the test:
  //   v.d <= 0      : compare |v|^2 with r^2 (start point is closest)
  //   v.d >= |d|^2  : compare |w|^2 with r^2 (stop point is closest)
  //   otherwise     : compare (v x d)^2 with r^2 * |d|^2 (perpendicular foot)
  // A zero-length segment gives v.d = 0 and so falls on the start point.
  //
  // Stage plan:
  //   1 differences       2 all small products   3 dot, lengths, cross
  //   4 region and |cross|  5 split partial products and distance compare
  //   6 partial product sums  7 final compare, output register

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned DW = W + 1;        // coordinate difference
  localparam int unsigned PW = 2 * DW;       // product of two differences
  localparam int unsigned SW = PW + 1;       // signed sum of two products
  localparam int unsigned UW = PW;           // unsigned squared length
  localparam int unsigned HW = UW / 2;       // half of a squared length
  localparam int unsigned RW = 2 * W;        // radius squared
  localparam int unsigned QW = HW + W;       // len2 half times rr half
  localparam int unsigned CW = 2 * UW;       // final squared terms

  typedef enum logic [1:0] {
    REG_START,
    REG_STOP,
    REG_FOOT
  } region_e;

  // --------------------------------------------------------------------------
  // Stage control
  // --------------------------------------------------------------------------
  pipe_ctrl_t ctrl;

  schc_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl)
  );

  assign in_ready_o  = ctrl.en[0];
  assign out_valid_o = ctrl.vld[NUM_STAGES-1];

  // --------------------------------------------------------------------------
  // Stage 1: coordinate differences, one bit wider than the fields.
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] s1_vx_q, s1_vy_q, s1_dx_q, s1_dy_q, s1_wx_q, s1_wy_q;
  logic signed [DW-1:0] s1_vx_d, s1_vy_d, s1_dx_d, s1_dy_d, s1_wx_d, s1_wy_d;
  logic        [W-1:0]  s1_rad_q;

  assign s1_vx_d = {center_x_i[W-1], center_x_i} - {start_x_i[W-1], start_x_i};
  assign s1_vy_d = {center_y_i[W-1], center_y_i} - {start_y_i[W-1], start_y_i};
  assign s1_dx_d = {stop_x_i[W-1], stop_x_i} - {start_x_i[W-1], start_x_i};
  assign s1_dy_d = {stop_y_i[W-1], stop_y_i} - {start_y_i[W-1], start_y_i};
  assign s1_wx_d = {center_x_i[W-1], center_x_i} - {stop_x_i[W-1], stop_x_i};
  assign s1_wy_d = {center_y_i[W-1], center_y_i} - {stop_y_i[W-1], stop_y_i};

  always_ff @(posedge clk_i) begin
    if (ctrl.en[0]) begin
      s1_vx_q  <= s1_vx_d;
      s1_vy_q  <= s1_vy_d;
      s1_dx_q  <= s1_dx_d;
      s1_dy_q  <= s1_dy_d;
      s1_wx_q  <= s1_wx_d;
      s1_wy_q  <= s1_wy_d;
      s1_rad_q <= radius_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: the products of two differences that the tests use, plus the radius squared.
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] s2_vxdx_q, s2_vydy_q, s2_dxdx_q, s2_dydy_q, s2_vxdy_q;
  logic signed [PW-1:0] s2_vydx_q, s2_vxvx_q, s2_vyvy_q, s2_wxwx_q, s2_wywy_q;
  logic signed [PW-1:0] s2_vxdx_d, s2_vydy_d, s2_dxdx_d, s2_dydy_d, s2_vxdy_d;
  logic signed [PW-1:0] s2_vydx_d, s2_vxvx_d, s2_vyvy_d, s2_wxwx_d, s2_wywy_d;
  logic        [RW-1:0] s2_rr_q, s2_rr_d;

  assign s2_vxdx_d = s1_vx_q * s1_dx_q;
  assign s2_vydy_d = s1_vy_q * s1_dy_q;
  assign s2_dxdx_d = s1_dx_q * s1_dx_q;
  assign s2_dydy_d = s1_dy_q * s1_dy_q;
  assign s2_vxdy_d = s1_vx_q * s1_dy_q;
  assign s2_vydx_d = s1_vy_q * s1_dx_q;
  assign s2_vxvx_d = s1_vx_q * s1_vx_q;
  assign s2_vyvy_d = s1_vy_q * s1_vy_q;
  assign s2_wxwx_d = s1_wx_q * s1_wx_q;
  assign s2_wywy_d = s1_wy_q * s1_wy_q;
  assign s2_rr_d   = RW'(s1_rad_q) * RW'(s1_rad_q);

  always_ff @(posedge clk_i) begin
    if (ctrl.en[1]) begin
      s2_vxdx_q <= s2_vxdx_d;
      s2_vydy_q <= s2_vydy_d;
      s2_dxdx_q <= s2_dxdx_d;
      s2_dydy_q <= s2_dydy_d;
      s2_vxdy_q <= s2_vxdy_d;
      s2_vydx_q <= s2_vydx_d;
      s2_vxvx_q <= s2_vxvx_d;
      s2_vyvy_q <= s2_vyvy_d;
      s2_wxwx_q <= s2_wxwx_d;
      s2_wywy_q <= s2_wywy_d;
      s2_rr_q   <= s2_rr_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: dot product, cross product and squared lengths. Squares are
  // never negative and their sums fit the unsigned width.
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] s3_dot_q, s3_dot_d, s3_cross_q, s3_cross_d;
  logic        [UW-1:0] s3_len2_q, s3_len2_d, s3_dv_q, s3_dv_d, s3_dw_q, s3_dw_d;
  logic        [RW-1:0] s3_rr_q;

  assign s3_dot_d   = SW'(s2_vxdx_q) + SW'(s2_vydy_q);
  assign s3_cross_d = SW'(s2_vxdy_q) - SW'(s2_vydx_q);
  assign s3_len2_d  = UW'($unsigned(s2_dxdx_q)) + UW'($unsigned(s2_dydy_q));
  assign s3_dv_d    = UW'($unsigned(s2_vxvx_q)) + UW'($unsigned(s2_vyvy_q));
  assign s3_dw_d    = UW'($unsigned(s2_wxwx_q)) + UW'($unsigned(s2_wywy_q));

  always_ff @(posedge clk_i) begin
    if (ctrl.en[2]) begin
      s3_dot_q   <= s3_dot_d;
      s3_cross_q <= s3_cross_d;
      s3_len2_q  <= s3_len2_d;
      s3_dv_q    <= s3_dv_d;
      s3_dw_q    <= s3_dw_d;
      s3_rr_q    <= s2_rr_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: pick the closest point's region, its distance for the end
  // cases and the magnitude of the cross product for the foot case.
  // --------------------------------------------------------------------------
  region_e              s4_region_q, s4_region_d;
  logic        [UW-1:0] s4_dist_q, s4_dist_d, s4_abscr_q, s4_abscr_d, s4_len2_q;
  logic        [RW-1:0] s4_rr_q;
  logic signed [SW-1:0] s4_negcr;

  assign s4_negcr = -s3_cross_q;

  always_comb begin
    if (s3_dot_q[SW-1] || (s3_dot_q == '0)) begin
      s4_region_d = REG_START;
    end else if ($signed({1'b0, s3_len2_q}) <= s3_dot_q) begin
      s4_region_d = REG_STOP;
    end else begin
      s4_region_d = REG_FOOT;
    end
  end

  assign s4_dist_d  = (s4_region_d == REG_STOP) ? s3_dw_q : s3_dv_q;
  assign s4_abscr_d = s3_cross_q[SW-1] ? UW'(s4_negcr) : UW'(s3_cross_q);

  always_ff @(posedge clk_i) begin
    if (ctrl.en[3]) begin
      s4_region_q <= s4_region_d;
      s4_dist_q   <= s4_dist_d;
      s4_abscr_q  <= s4_abscr_d;
      s4_len2_q   <= s3_len2_q;
      s4_rr_q     <= s3_rr_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: the end-point compare, and the two wide products of the foot
  // case cut into half-width partial products.
  // --------------------------------------------------------------------------
  region_e           s5_region_q;
  logic              s5_dist_le_q, s5_dist_le_d;
  logic [2*HW-1:0]   s5_pp_hh_q, s5_pp_hl_q, s5_pp_ll_q;
  logic [2*HW-1:0]   s5_pp_hh_d, s5_pp_hl_d, s5_pp_ll_d;
  logic [QW-1:0]     s5_q_hh_q, s5_q_hl_q, s5_q_lh_q, s5_q_ll_q;
  logic [QW-1:0]     s5_q_hh_d, s5_q_hl_d, s5_q_lh_d, s5_q_ll_d;
  logic [HW-1:0]     s5_a_hi, s5_a_lo, s5_l_hi, s5_l_lo;
  logic [W-1:0]      s5_r_hi, s5_r_lo;

  assign s5_a_hi = s4_abscr_q[UW-1:HW];
  assign s5_a_lo = s4_abscr_q[HW-1:0];
  assign s5_l_hi = s4_len2_q[UW-1:HW];
  assign s5_l_lo = s4_len2_q[HW-1:0];
  assign s5_r_hi = s4_rr_q[RW-1:W];
  assign s5_r_lo = s4_rr_q[W-1:0];

  assign s5_dist_le_d = s4_dist_q <= UW'(s4_rr_q);
  assign s5_pp_hh_d   = (2*HW)'(s5_a_hi) * (2*HW)'(s5_a_hi);
  assign s5_pp_hl_d   = (2*HW)'(s5_a_hi) * (2*HW)'(s5_a_lo);
  assign s5_pp_ll_d   = (2*HW)'(s5_a_lo) * (2*HW)'(s5_a_lo);
  assign s5_q_hh_d    = QW'(s5_l_hi) * QW'(s5_r_hi);
  assign s5_q_hl_d    = QW'(s5_l_hi) * QW'(s5_r_lo);
  assign s5_q_lh_d    = QW'(s5_l_lo) * QW'(s5_r_hi);
  assign s5_q_ll_d    = QW'(s5_l_lo) * QW'(s5_r_lo);

  always_ff @(posedge clk_i) begin
    if (ctrl.en[4]) begin
      s5_region_q  <= s4_region_q;
      s5_dist_le_q <= s5_dist_le_d;
      s5_pp_hh_q   <= s5_pp_hh_d;
      s5_pp_hl_q   <= s5_pp_hl_d;
      s5_pp_ll_q   <= s5_pp_ll_d;
      s5_q_hh_q    <= s5_q_hh_d;
      s5_q_hl_q    <= s5_q_hl_d;
      s5_q_lh_q    <= s5_q_lh_d;
      s5_q_ll_q    <= s5_q_ll_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: recombine the partial products into (v x d)^2 and r^2 * |d|^2.
  // --------------------------------------------------------------------------
  region_e       s6_region_q;
  logic          s6_dist_le_q;
  logic [CW-1:0] s6_cr2_q, s6_cr2_d, s6_rl_q, s6_rl_d;

  assign s6_cr2_d = (CW'(s5_pp_hh_q) << (2 * HW))
                  + (CW'(s5_pp_hl_q) << (HW + 1))
                  + CW'(s5_pp_ll_q);
  assign s6_rl_d  = (CW'(s5_q_hh_q) << (HW + W))
                  + (CW'(s5_q_hl_q) << HW)
                  + (CW'(s5_q_lh_q) << W)
                  + CW'(s5_q_ll_q);

  always_ff @(posedge clk_i) begin
    if (ctrl.en[5]) begin
      s6_region_q  <= s5_region_q;
      s6_dist_le_q <= s5_dist_le_q;
      s6_cr2_q     <= s6_cr2_d;
      s6_rl_q      <= s6_rl_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: final decision into the output register.
  // --------------------------------------------------------------------------
  logic hit_q, hit_d;

  always_comb begin
    case (s6_region_q)
      REG_FOOT: hit_d = s6_cr2_q <= s6_rl_q;
      default:  hit_d = s6_dist_le_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en[6]) begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // With nothing waiting at the output every stage can move, so the input
  // side must be open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while the output register is empty");

  // A zero-length segment must resolve to the start point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.en[3] && ctrl.vld[2] && (s3_len2_q == '0)) |=> (s4_region_q == REG_START))
    else $error("zero-length segment not resolved to its start point");

  // The perpendicular foot only exists on a segment of nonzero length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.vld[3] && (s4_region_q == REG_FOOT)) |-> (s4_len2_q != '0))
    else $error("foot region selected for a zero-length segment");

endmodule : segment_circle_hit_test

`default_nettype wire

### src/schc_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// schc_pipe_ctrl: valid and load-enable chain for the hit test pipeline
// Each stage loads when it is empty or when the stage after it moves on,
// so bubbles close up and a stall at the output loses nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module schc_pipe_ctrl
  import schc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic out_ready_i,
  output pipe_ctrl_t ctrl_o
);

  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES-1:0] vld_d;
  logic [NUM_STAGES:0]   en;

  always_comb begin
    en[NUM_STAGES] = out_ready_i;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ctrl_o.en  = en[NUM_STAGES-1:0];
  assign ctrl_o.vld = vld_q;

endmodule : schc_pipe_ctrl

`default_nettype wire
